// File: rtl/epss_pkg.sv
// ----------------------------------------------------------------------------
// epss_pkg
// Shared constants, types and character-class helpers for the endpoint
// string scanner.
// ----------------------------------------------------------------------------
package epss_pkg;

  localparam int MAX_LEN = 256;
  localparam int POS_W   = $clog2(MAX_LEN + 1);

  // address kinds
  localparam logic [1:0] AK_NONE = 2'd0;
  localparam logic [1:0] AK_IPV4 = 2'd1;
  localparam logic [1:0] AK_IPV6 = 2'd2;
  localparam logic [1:0] AK_HOST = 2'd3;

  // port kinds
  localparam logic [1:0] PK_NONE    = 2'd0;
  localparam logic [1:0] PK_NUMERIC = 2'd1;
  localparam logic [1:0] PK_SERVICE = 2'd2;

  // characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_PERIOD = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;

  localparam int RES_W  = 54;
  localparam int TDATA_W = 56;

  typedef struct packed {
    logic        too_long;
    logic [15:0] port_value;
    logic [7:0]  port_length;
    logic [7:0]  port_start;
    logic [1:0]  port_kind;
    logic [7:0]  address_length;
    logic [7:0]  address_start;
    logic [1:0]  address_kind;
    logic        parse_ok;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_hex_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // times ten plus digit, saturated to 16 bits
  function automatic logic [15:0] accumulate(input logic [15:0] a, input logic [7:0] c);
    logic [19:0] v;
    v = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {12'b0, c - CH_ZERO};
    return (v > 20'd65535) ? 16'hffff : v[15:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [POS_W-1:0] v);
    return (32'(v) > 32'd255) ? 8'hff : 8'(v);
  endfunction

endpackage

// File: rtl/epss_scan.sv
// ----------------------------------------------------------------------------
// epss_scan
// Character-class state machine: advances the scan state on every character
// until a failure or overrun, and forms the result of the string when the NUL arrives.
// ----------------------------------------------------------------------------
module epss_scan import epss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_code,
  output res_t       res
);

  localparam logic [3:0] ST_START   = 4'd0;
  localparam logic [3:0] ST_DIGIT   = 4'd1;
  localparam logic [3:0] ST_PERIOD  = 4'd2;
  localparam logic [3:0] ST_LETTER  = 4'd3;
  localparam logic [3:0] ST_HOST    = 4'd4;
  localparam logic [3:0] ST_IPV6    = 4'd5;
  localparam logic [3:0] ST_NEXT    = 4'd6;
  localparam logic [3:0] ST_COLON   = 4'd7;
  localparam logic [3:0] ST_PORT    = 4'd8;
  localparam logic [3:0] ST_SERVICE = 4'd9;

  logic [3:0]       state_r,      state_nxt;
  logic [POS_W-1:0] pos_r,        pos_nxt;
  logic [POS_W-1:0] mark_r,       mark_nxt;
  logic [1:0]       akind_r,      akind_nxt;
  logic [POS_W-1:0] astart_r,     astart_nxt;
  logic [POS_W-1:0] alen_r,       alen_nxt;
  logic [15:0]      accum_r,      accum_nxt;
  logic             failed_r,     failed_nxt;
  logic             overrun_r,    overrun_nxt;

  logic             is_nul;
  logic [POS_W-1:0] span_len;
  logic             adv_fail;
  logic             set_addr;
  logic [1:0]       set_kind;

  assign is_nul   = (char_code == CH_NUL);
  assign span_len = pos_r - mark_r;

  // next state for one non-NUL character
  always_comb begin
    state_nxt = state_r;
    mark_nxt  = mark_r;
    accum_nxt = accum_r;
    adv_fail  = 1'b0;
    set_addr  = 1'b0;
    set_kind  = AK_NONE;
    unique case (state_r)
      ST_START: begin
        if (char_code == CH_SPACE || char_code == CH_TAB) begin
        end else if (char_code == CH_COLON) begin
          accum_nxt = '0;
          state_nxt = ST_COLON;
        end else if (char_code == CH_LBRACK) begin
          mark_nxt  = pos_r + POS_W'(1);
          state_nxt = ST_IPV6;
        end else if (is_digit(char_code)) begin
          mark_nxt  = pos_r;
          accum_nxt = accumulate(16'd0, char_code);
          state_nxt = ST_DIGIT;
        end else if (is_alpha(char_code)) begin
          mark_nxt  = pos_r;
          state_nxt = ST_LETTER;
        end else begin
          adv_fail = 1'b1;
        end
      end
      ST_DIGIT: begin
        if (char_code == CH_PERIOD) state_nxt = ST_PERIOD;
        else if (char_code == CH_HYPHEN) state_nxt = ST_LETTER;
        else if (is_digit(char_code)) accum_nxt = accumulate(accum_r, char_code);
        else if (is_alpha(char_code)) state_nxt = ST_LETTER;
        else adv_fail = 1'b1;
      end
      ST_PERIOD: begin
        if (char_code == CH_PERIOD || is_digit(char_code)) begin
        end else if (char_code == CH_HYPHEN) begin
          state_nxt = ST_HOST;
        end else if (char_code == CH_COLON) begin
          set_addr  = 1'b1;
          set_kind  = AK_IPV4;
          accum_nxt = '0;
          state_nxt = ST_COLON;
        end else if (is_alpha(char_code)) begin
          state_nxt = ST_LETTER;
        end else begin
          adv_fail = 1'b1;
        end
      end
      ST_LETTER, ST_HOST: begin
        if (char_code == CH_PERIOD || char_code == CH_HYPHEN) begin
          state_nxt = ST_HOST;
        end else if (char_code == CH_COLON) begin
          set_addr  = 1'b1;
          set_kind  = AK_HOST;
          accum_nxt = '0;
          state_nxt = ST_COLON;
        end else if (!(is_digit(char_code) || is_alpha(char_code))) begin
          adv_fail = 1'b1;
        end
      end
      ST_IPV6: begin
        if (char_code == CH_RBRACK) begin
          set_addr  = 1'b1;
          set_kind  = AK_IPV6;
          state_nxt = ST_NEXT;
        end else if (!(char_code == CH_COLON || char_code == CH_PERIOD ||
                       is_digit(char_code) || is_hex_alpha(char_code))) begin
          adv_fail = 1'b1;
        end
      end
      ST_NEXT: begin
        if (char_code == CH_COLON) begin
          accum_nxt = '0;
          state_nxt = ST_COLON;
        end else begin
          adv_fail = 1'b1;
        end
      end
      ST_COLON: begin
        if (is_digit(char_code)) begin
          mark_nxt  = pos_r;
          accum_nxt = accumulate(16'd0, char_code);
          state_nxt = ST_PORT;
        end else if (is_alpha(char_code)) begin
          mark_nxt  = pos_r;
          state_nxt = ST_SERVICE;
        end else begin
          adv_fail = 1'b1;
        end
      end
      ST_PORT: begin
        if (is_digit(char_code)) accum_nxt = accumulate(accum_r, char_code);
        else adv_fail = 1'b1;
      end
      ST_SERVICE: begin
        if (!(is_digit(char_code) || is_alpha(char_code))) adv_fail = 1'b1;
      end
      default: adv_fail = 1'b1;
    endcase
  end

  // register update
  always_comb begin
    pos_nxt     = pos_r;
    akind_nxt   = akind_r;
    astart_nxt  = astart_r;
    alen_nxt    = alen_r;
    failed_nxt  = failed_r;
    overrun_nxt = overrun_r;
    if (is_nul) begin
      // string done: back to the reset values
      pos_nxt     = '0;
      akind_nxt   = AK_NONE;
      astart_nxt  = '0;
      alen_nxt    = '0;
      failed_nxt  = 1'b0;
      overrun_nxt = 1'b0;
    end else if (pos_r >= POS_W'(MAX_LEN)) begin
      overrun_nxt = 1'b1;
      failed_nxt  = 1'b1;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
      if (!failed_r) begin
        failed_nxt = adv_fail;
        if (set_addr) begin
          akind_nxt  = set_kind;
          astart_nxt = mark_r;
          alen_nxt   = span_len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_START;
      pos_r     <= '0;
      mark_r    <= '0;
      akind_r   <= AK_NONE;
      astart_r  <= '0;
      alen_r    <= '0;
      accum_r   <= '0;
      failed_r  <= 1'b0;
      overrun_r <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      akind_r   <= akind_nxt;
      astart_r  <= astart_nxt;
      alen_r    <= alen_nxt;
      failed_r  <= failed_nxt;
      overrun_r <= overrun_nxt;
      if (is_nul) begin
        state_r <= ST_START;
        mark_r  <= '0;
        accum_r <= '0;
      end else if (!failed_r && pos_r < POS_W'(MAX_LEN)) begin
        state_r <= state_nxt;
        mark_r  <= mark_nxt;
        accum_r <= accum_nxt;
      end
    end
  end

  // end-of-string result
  logic             fin_fail;
  logic [1:0]       fin_akind;
  logic [POS_W-1:0] fin_astart;
  logic [POS_W-1:0] fin_alen;
  logic [1:0]       fin_pkind;

  always_comb begin
    fin_fail   = failed_r;
    fin_akind  = akind_r;
    fin_astart = astart_r;
    fin_alen   = alen_r;
    fin_pkind  = PK_NONE;
    unique case (state_r)
      ST_DIGIT, ST_PORT: fin_pkind = PK_NUMERIC;
      ST_SERVICE:        fin_pkind = PK_SERVICE;
      ST_PERIOD, ST_LETTER, ST_HOST: begin
        fin_akind  = (state_r == ST_PERIOD) ? AK_IPV4 : AK_HOST;
        fin_astart = mark_r;
        fin_alen   = span_len;
      end
      ST_NEXT, ST_COLON: begin
      end
      default: fin_fail = 1'b1;
    endcase
  end

  always_comb begin
    res          = '0;
    res.parse_ok = !fin_fail;
    res.too_long = overrun_r;
    if (!fin_fail) begin
      res.address_kind   = fin_akind;
      res.address_start  = sat8(fin_astart);
      res.address_length = sat8(fin_alen);
      res.port_kind      = fin_pkind;
      if (fin_pkind != PK_NONE) begin
        res.port_start  = sat8(mark_r);
        res.port_length = sat8(span_len);
      end
      if (fin_pkind == PK_NUMERIC) res.port_value = accum_r;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_LEN))
    else $error("character position beyond maximum length");

  a_nul_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_nul |=> state_r == ST_START && pos_r == '0 && !failed_r)
    else $error("scanner not cleared after end of string");

  a_overrun_fails: assert property (@(posedge clk) disable iff (!rst_n)
    overrun_r |-> failed_r)
    else $error("overrun without failure");

  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !failed_r && state_r != ST_START && state_r != ST_COLON && state_r != ST_NEXT
      |-> mark_r <= pos_r)
    else $error("span mark ahead of position");

endmodule

// File: rtl/endpoint_string_scanner_unit.sv
// ----------------------------------------------------------------------------
// endpoint_string_scanner_unit
// Endpoint text scanner: one character per transfer in, one result per
// NUL-terminated string out.
// ----------------------------------------------------------------------------
// Takes one character per cycle while not stalled. A character transfer is
// registered, then the scan state machine steps on it; the result of a string is
// loaded into the output register on the step of its NUL, so out_tvalid rises
// once the NUL has passed the input register and stepped. Sustained rate is one
// character per cycle while not stalled; input only stalls while a finished
// result sits unread and the next NUL is waiting behind it.
module endpoint_string_scanner_unit import epss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] char_code
  output logic               out_tvalid,
  input  logic               out_tready,
  // [0] parse_ok, [2:1] address_kind, [10:3] address_start,
  // [18:11] address_length, [20:19] port_kind, [28:21] port_start,
  // [36:29] port_length, [52:37] port_value, [53] too_long, [55:54] zero
  output logic [TDATA_W-1:0] out_tdata
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_go;
  logic       out_free;
  logic       out_valid_r;
  res_t       res;
  res_t       res_r;

  assign out_free  = !out_valid_r || out_tready;
  // a NUL may only step when the result register can take its result
  assign s1_go     = s1_valid_r && ((s1_char_r != CH_NUL) || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_char_r <= in_tdata;
    end
  end

  epss_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_go),
    .char_code (s1_char_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_char_r == CH_NUL) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_char_r == CH_NUL) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - RES_W){1'b0}}, res_r};

endmodule

// File: test/tb_endpoint_string_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_endpoint_string_scanner_unit
// Streams endpoint texts into the scanner one character per transfer and
// checks every result against an in-bench scanner model: a directed set of
// corner strings, then random well-formed endpoints, broken ones, noise and a
// few overlong strings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_endpoint_string_scanner_unit;
  import epss_pkg::*;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          RANDOM_CHARS = 1200;
  localparam logic [7:0]  CH_NINE      = 8'h39;
  localparam logic [7:0]  CH_LOWER_A   = 8'h61;
  localparam logic [7:0]  CH_UPPER_A   = 8'h41;

  typedef enum logic [3:0] {
    SC_START, SC_DIGIT, SC_PERIOD, SC_LETTER, SC_HOST,
    SC_IPV6, SC_NEXT, SC_COLON, SC_PORT, SC_SERVICE
  } scan_state_e;

  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } feed_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = 8'h00;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;

  feed_t      feed_q[$];
  logic [7:0] text_buf[$];
  res_t       expected_results[$];
  res_t       next_result;
  bit         in_took = 1'b0;
  int         cycle_count = 0;
  int         fail_count = 0;
  int         result_count = 0;
  logic       calm;

  // scanner model state
  scan_state_e sc_state;
  int unsigned sc_pos, sc_mark, sc_addr_start, sc_addr_len, sc_port_start;
  logic [1:0]  sc_addr_kind, sc_port_kind;
  logic [15:0] sc_accum;
  bit          sc_bad, sc_overrun;

  endpoint_string_scanner_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling on either side in this window
  assign calm = (cycle_count >= 400) && (cycle_count < 900);

  function automatic bit digit_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic bit letter_char(input logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c < CH_LOWER_A + 8'd26)) ||
           ((c >= CH_UPPER_A) && (c < CH_UPPER_A + 8'd26));
  endfunction

  function automatic bit hex_letter_char(input logic [7:0] c);
    return ((c >= CH_LOWER_A) && (c < CH_LOWER_A + 8'd6)) ||
           ((c >= CH_UPPER_A) && (c < CH_UPPER_A + 8'd6));
  endfunction

  function automatic logic [7:0] clip8(input int unsigned v);
    return (v > 255) ? 8'hff : v[7:0];
  endfunction

  task automatic scan_clear();
    sc_state = SC_START;
    sc_pos = 0;
    sc_mark = 0;
    sc_addr_kind = AK_NONE;
    sc_addr_start = 0;
    sc_addr_len = 0;
    sc_port_kind = PK_NONE;
    sc_port_start = 0;
    sc_accum = '0;
    sc_bad = 1'b0;
    sc_overrun = 1'b0;
  endtask

  task automatic tally(input logic [7:0] c);
    int unsigned v;
    v = 32'(sc_accum) * 32'd10 + 32'(c) - 32'(CH_ZERO);
    sc_accum = (v > 65535) ? 16'hffff : v[15:0];
  endtask

  task automatic mark_address(input logic [1:0] kind);
    sc_addr_kind = kind;
    sc_addr_start = sc_mark;
    sc_addr_len = sc_pos - sc_mark;
  endtask

  task automatic scan_step(input logic [7:0] c);
    int unsigned at;
    at = sc_pos;
    case (sc_state)
      SC_START: begin
        if (c == CH_SPACE || c == CH_TAB) begin
        end else if (c == CH_COLON) begin
          sc_accum = '0;
          sc_state = SC_COLON;
        end else if (c == CH_LBRACK) begin
          sc_mark = at + 1;
          sc_state = SC_IPV6;
        end else if (digit_char(c)) begin
          sc_mark = at;
          sc_accum = '0;
          tally(c);
          sc_state = SC_DIGIT;
        end else if (letter_char(c)) begin
          sc_mark = at;
          sc_state = SC_LETTER;
        end else begin
          sc_bad = 1'b1;
        end
      end
      SC_DIGIT: begin
        if (c == CH_PERIOD) sc_state = SC_PERIOD;
        else if (c == CH_HYPHEN) sc_state = SC_LETTER;
        else if (digit_char(c)) tally(c);
        else if (letter_char(c)) sc_state = SC_LETTER;
        else sc_bad = 1'b1;
      end
      SC_PERIOD: begin
        if (c == CH_PERIOD || digit_char(c)) begin
        end else if (c == CH_HYPHEN) begin
          sc_state = SC_HOST;
        end else if (c == CH_COLON) begin
          mark_address(AK_IPV4);
          sc_accum = '0;
          sc_state = SC_COLON;
        end else if (letter_char(c)) begin
          sc_state = SC_LETTER;
        end else begin
          sc_bad = 1'b1;
        end
      end
      SC_LETTER, SC_HOST: begin
        if (c == CH_PERIOD || c == CH_HYPHEN) begin
          sc_state = SC_HOST;
        end else if (c == CH_COLON) begin
          mark_address(AK_HOST);
          sc_accum = '0;
          sc_state = SC_COLON;
        end else if (!(digit_char(c) || letter_char(c))) begin
          sc_bad = 1'b1;
        end
      end
      SC_IPV6: begin
        if (c == CH_RBRACK) begin
          mark_address(AK_IPV6);
          sc_state = SC_NEXT;
        end else if (!(c == CH_COLON || c == CH_PERIOD || digit_char(c) ||
                       hex_letter_char(c))) begin
          sc_bad = 1'b1;
        end
      end
      SC_NEXT: begin
        if (c == CH_COLON) begin
          sc_accum = '0;
          sc_state = SC_COLON;
        end else begin
          sc_bad = 1'b1;
        end
      end
      SC_COLON: begin
        if (digit_char(c)) begin
          sc_mark = at;
          sc_accum = '0;
          tally(c);
          sc_state = SC_PORT;
        end else if (letter_char(c)) begin
          sc_mark = at;
          sc_state = SC_SERVICE;
        end else begin
          sc_bad = 1'b1;
        end
      end
      SC_PORT: begin
        if (digit_char(c)) tally(c);
        else sc_bad = 1'b1;
      end
      SC_SERVICE: begin
        if (!(digit_char(c) || letter_char(c))) sc_bad = 1'b1;
      end
      default: sc_bad = 1'b1;
    endcase
  endtask

  // NUL: settle the open span and form the result
  task automatic close_string(output res_t r);
    int unsigned span;
    span = sc_pos - sc_mark;
    if (!sc_bad) begin
      case (sc_state)
        SC_DIGIT, SC_PORT: begin
          sc_port_kind = PK_NUMERIC;
          sc_port_start = sc_mark;
        end
        SC_SERVICE: begin
          sc_port_kind = PK_SERVICE;
          sc_port_start = sc_mark;
        end
        SC_PERIOD:          mark_address(AK_IPV4);
        SC_LETTER, SC_HOST: mark_address(AK_HOST);
        SC_NEXT, SC_COLON: begin
        end
        default:            sc_bad = 1'b1;
      endcase
    end
    r = '0;
    r.parse_ok = !sc_bad;
    if (!sc_bad) begin
      r.address_kind = sc_addr_kind;
      r.address_start = clip8(sc_addr_start);
      r.address_length = clip8(sc_addr_len);
      r.port_kind = sc_port_kind;
      if (sc_port_kind != PK_NONE) begin
        r.port_start = clip8(sc_port_start);
        r.port_length = clip8(span);
      end
      if (sc_port_kind == PK_NUMERIC) r.port_value = sc_accum;
    end
    r.too_long = sc_overrun;
    scan_clear();
  endtask

  task automatic scan_char(input logic [7:0] c);
    if (sc_pos >= MAX_LEN) begin
      sc_overrun = 1'b1;
      sc_bad = 1'b1;
    end else begin
      if (!sc_bad) scan_step(c);
      sc_pos++;
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at result %0d: %s got %0h want %0h",
             result_count, what, got, want);
    fail_count++;
  endtask

  task automatic match_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // input transfers feed the model
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      if (in_tdata == CH_NUL) begin
        close_string(next_result);
        expected_results.push_back(next_result);
      end else begin
        scan_char(in_tdata);
      end
    end
  end

  // result transfers
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[RES_W-1:0];
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", 0, 0);
      end else begin
        want = expected_results.pop_front();
        match_field("parse_ok", got.parse_ok, want.parse_ok);
        match_field("address_kind", got.address_kind, want.address_kind);
        match_field("address_start", got.address_start, want.address_start);
        match_field("address_length", got.address_length, want.address_length);
        match_field("port_kind", got.port_kind, want.port_kind);
        match_field("port_start", got.port_start, want.port_start);
        match_field("port_length", got.port_length, want.port_length);
        match_field("port_value", got.port_value, want.port_value);
        match_field("too_long", got.too_long, want.too_long);
        match_field("pad bits", out_tdata[TDATA_W-1:RES_W], 0);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_endpoint_string_scanner_unit failed");
      $finish;
    end
  end

  // character driver and result-side stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 17);
      if (!in_tvalid || in_took) begin
        if (feed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 17) &&
            !(feed_q[0].drain && expected_results.size() != 0)) begin
          in_tvalid <= 1'b1;
          in_tdata <= feed_q[0].ch;
          void'(feed_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_v6();
    case ($urandom_range(0, 3))
      0:       return pick_digit();
      1:       return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) +
                      8'($urandom_range(0, 5));
      2:       return CH_COLON;
      default: return CH_PERIOD;
    endcase
  endfunction

  function automatic logic [7:0] pick_host();
    case ($urandom_range(0, 5))
      0:       return pick_digit();
      1:       return CH_PERIOD;
      2:       return CH_HYPHEN;
      default: return pick_letter();
    endcase
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // queue the text plus its NUL; drain holds the first char until all results are in
  task automatic end_text(input bit drain);
    feed_t f;
    text_buf.push_back(CH_NUL);
    foreach (text_buf[i]) begin
      f.ch = text_buf[i];
      f.drain = drain && (i == 0);
      feed_q.push_back(f);
    end
    text_buf.delete();
  endtask

  task automatic build_endpoint();
    int groups;
    repeat ($urandom_range(0, 2)) text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(0, 5))
      0: begin
        groups = $urandom_range(1, 4);
        for (int g = 0; g < groups; g++) begin
          if (g != 0) text_buf.push_back(CH_PERIOD);
          repeat ($urandom_range(1, 3)) text_buf.push_back(pick_digit());
        end
      end
      1: begin
        text_buf.push_back(CH_LBRACK);
        repeat ($urandom_range(0, 12)) text_buf.push_back(pick_v6());
        text_buf.push_back(CH_RBRACK);
      end
      2: begin
        text_buf.push_back(pick_letter());
        repeat ($urandom_range(0, 10)) text_buf.push_back(pick_host());
      end
      3: repeat ($urandom_range(1, 7)) text_buf.push_back(pick_digit());
      4: begin
      end
      default: begin
        repeat ($urandom_range(1, 3)) text_buf.push_back(pick_digit());
        text_buf.push_back($urandom_range(0, 1) ? CH_HYPHEN : pick_letter());
        repeat ($urandom_range(0, 5)) text_buf.push_back(pick_host());
      end
    endcase
    case ($urandom_range(0, 3))
      0: begin
      end
      1: begin
        text_buf.push_back(CH_COLON);
        repeat ($urandom_range(1, 7)) text_buf.push_back(pick_digit());
      end
      2: begin
        text_buf.push_back(CH_COLON);
        text_buf.push_back(pick_letter());
        repeat ($urandom_range(0, 6))
          text_buf.push_back($urandom_range(0, 2) ? pick_letter() : pick_digit());
      end
      default: text_buf.push_back(CH_COLON);
    endcase
  endtask

  initial begin
    int random_chars;
    int strings_made;
    int pick;

    scan_clear();

    // directed corner strings
    end_text(1'b0);                        // empty
    push_text(" \t");        end_text(1'b0);
    push_text("[a");         end_text(1'b0);   // unclosed bracket
    push_text("1.:");        end_text(1'b0);   // colon with nothing after it
    push_text("9-z");        end_text(1'b0);   // digit then hyphen
    text_buf.push_back(8'hff);
    push_text("!");          end_text(1'b0);   // error then ignored chars
    push_text("[f]:99999");  end_text(1'b0);   // saturated port
    push_text(":s");         end_text(1'b0);

    random_chars = 0;
    strings_made = 0;
    while (random_chars < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (strings_made % 8 == 4 && strings_made < 32) begin
        // overlong and wide-span strings
        case (strings_made / 8)
          0:       repeat (256) text_buf.push_back(pick_letter());
          1:       repeat (257) text_buf.push_back(pick_letter());
          2: begin
            repeat (253) text_buf.push_back(CH_SPACE);
            push_text("1.2");
          end
          default: begin
            repeat ($urandom_range(200, 280)) text_buf.push_back(CH_TAB);
            push_text(":80");
          end
        endcase
        random_chars += text_buf.size() + 1;
        end_text(1'b1);
      end else begin
        if (pick < 80) begin
          build_endpoint();
          if ($urandom_range(0, 99) < 15 && text_buf.size() != 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(1, 255));
          else if ($urandom_range(0, 99) < 5 && text_buf.size() != 0)
            repeat ($urandom_range(1, text_buf.size())) void'(text_buf.pop_back());
        end else begin
          repeat ($urandom_range(0, 8)) text_buf.push_back(8'($urandom_range(1, 255)));
        end
        random_chars += text_buf.size() + 1;
        end_text(strings_made == 40);
      end
      strings_made++;
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (feed_q.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_endpoint_string_scanner_unit passed");
    end else begin
      $display("tb_endpoint_string_scanner_unit failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/epss_pkg.sv
rtl/epss_scan.sv
rtl/endpoint_string_scanner_unit.sv
test/tb_endpoint_string_scanner_unit.sv
